[rtl/salt_pepper_switching_median3x3_top_macros.svh]
// Assertion macros used by the switching median filter RTL.
`ifndef SALT_PEPPER_SWITCHING_MEDIAN3X3_TOP_MACROS_SVH
`define SALT_PEPPER_SWITCHING_MEDIAN3X3_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SMPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("switching median: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SMPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("switching median: next-cycle check failed");

`endif

[rtl/smpm_pkg.sv]
// Package with widths, register codes, types and helpers of the switching median filter.
`default_nettype none

package smpm_pkg;

    localparam int PIX_W     = 8;
    localparam int KEEP_W    = 4;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_N     = 9;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [KEEP_W-1:0] keep_t;
    typedef logic [CNT_W-1:0]  count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SALT_LEVEL   = 2'd0,
        CFG_PEPPER_LEVEL = 2'd1,
        CFG_KEEP_COUNT   = 2'd2
    } cfg_idx_t;

    localparam pixel_t SALT_RESET   = 8'd255;
    localparam pixel_t PEPPER_RESET = 8'd0;
    localparam keep_t  KEEP_RESET   = 4'd3;

    typedef struct packed {
        pixel_t salt_level;
        pixel_t pepper_level;
        keep_t  keep_count;
    } cfg_t;

    function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t pix_max(input pixel_t a, input pixel_t b);
        return (a < b) ? b : a;
    endfunction

endpackage

`default_nettype wire

[rtl/smpm_if.sv]
// Channel interfaces: window input and filtered pixel output.
`default_nettype none

interface smpm_win_if import smpm_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t top_left;
    pixel_t top_mid;
    pixel_t top_right;
    pixel_t mid_left;
    pixel_t center;
    pixel_t mid_right;
    pixel_t bot_left;
    pixel_t bot_mid;
    pixel_t bot_right;

    modport source (
        output valid, top_left, top_mid, top_right, mid_left, center,
               mid_right, bot_left, bot_mid, bot_right,
        input  ready
    );
    modport sink (
        input  valid, top_left, top_mid, top_right, mid_left, center,
               mid_right, bot_left, bot_mid, bot_right,
        output ready
    );
endinterface

interface smpm_pix_if import smpm_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t out_pixel;

    modport source (output valid, out_pixel, input ready);
    modport sink (input valid, out_pixel, output ready);
endinterface

`default_nettype wire

[rtl/smpm_sort3.sv]
// Three-input sorter on pixels.
`default_nettype none

module smpm_sort3 import smpm_pkg::*;
(
    input  wire pixel_t a,
    input  wire pixel_t b,
    input  wire pixel_t c,
    output pixel_t      lo,
    output pixel_t      mid,
    output pixel_t      hi
);

    pixel_t ab_lo;
    pixel_t ab_hi;
    pixel_t mc;

    always_comb
    begin
        ab_lo = pix_min(a, b);
        ab_hi = pix_max(a, b);
        mc    = pix_min(ab_hi, c);
        hi    = pix_max(ab_hi, c);
        lo    = pix_min(ab_lo, mc);
        mid   = pix_max(ab_lo, mc);
    end

endmodule

`default_nettype wire

[rtl/smpm_cfg.sv]
// Configuration registers of the switching median filter.
`default_nettype none

module smpm_cfg import smpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire pixel_t               cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SALT_LEVEL:   cfg_next.salt_level   = cfg_data;
                CFG_PEPPER_LEVEL: cfg_next.pepper_level = cfg_data;
                CFG_KEEP_COUNT:   cfg_next.keep_count   = cfg_data[KEEP_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.salt_level   <= SALT_RESET;
            cfg_reg.pepper_level <= PEPPER_RESET;
            cfg_reg.keep_count   <= KEEP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/salt_pepper_switching_median3x3_top.sv]
// Top level of the 3x3 switching median filter for salt and pepper noise.
//
//  Port   | Dir | Carries
//  -------+-----+------------------------------------------------
//  win    | in  | one 3x3 window of 8-bit pixels per item
//  pix    | out | one filtered 8-bit pixel per item
//  cfg_*  | in  | write-only salt level, pepper level, keep count
//
// One item enters per clock while win.ready is high.
// Stage one sorts the rows and counts extremes, stage two reduces the columns
// and decides, stage three takes the final median of three and selects.
// Reset clears the stage valid bits and loads the register defaults.
// A stage loads whenever it is empty or its content moves on, so ready
// falls only when all three stages hold items and the output is stalled.
`default_nettype none

`include "salt_pepper_switching_median3x3_top_macros.svh"

module salt_pepper_switching_median3x3_top import smpm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    smpm_win_if.sink                  win,
    smpm_pix_if.source                pix,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire pixel_t               cfg_data
);

    cfg_t   cfg;
    pixel_t w [WIN_N];

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;

    pixel_t row_lo_next  [3];
    pixel_t row_mid_next [3];
    pixel_t row_hi_next  [3];
    pixel_t row_lo_reg   [3];
    pixel_t row_mid_reg  [3];
    pixel_t row_hi_reg   [3];

    logic               is_salt;
    logic               s1_extreme_next;
    logic               s1_extreme_reg;
    pixel_t             level;
    logic [WIN_N-1:0]   match;
    count_t             s1_count_next;
    count_t             s1_count_reg;
    pixel_t             s1_center_reg;

    pixel_t s2_lo_next;
    pixel_t s2_mid_next;
    pixel_t s2_hi_next;
    logic   s2_replace_next;
    pixel_t s2_lo_reg;
    pixel_t s2_mid_reg;
    pixel_t s2_hi_reg;
    logic   s2_replace_reg;
    pixel_t s2_center_reg;

    pixel_t out_pixel_next;
    pixel_t out_pixel_reg;

    smpm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign w[0] = win.top_left;
    assign w[1] = win.top_mid;
    assign w[2] = win.top_right;
    assign w[3] = win.mid_left;
    assign w[4] = win.center;
    assign w[5] = win.mid_right;
    assign w[6] = win.bot_left;
    assign w[7] = win.bot_mid;
    assign w[8] = win.bot_right;

    assign s3_ready  = !s3_valid_reg || pix.ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign win.ready = s1_ready;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        smpm_sort3 u_sort (
            .a   (w[3*r]),
            .b   (w[3*r+1]),
            .c   (w[3*r+2]),
            .lo  (row_lo_next[r]),
            .mid (row_mid_next[r]),
            .hi  (row_hi_next[r])
        );
    end

    always_comb
    begin
        is_salt         = (win.center == cfg.salt_level);
        s1_extreme_next = is_salt || (win.center == cfg.pepper_level);
        level           = is_salt ? cfg.salt_level : cfg.pepper_level;
        for (int i = 0; i < WIN_N; i++)
        begin
            match[i] = (w[i] == level);
        end
        s1_count_next = CNT_W'($countones(match));
    end

    always_comb
    begin
        s2_lo_next      = pix_max(pix_max(row_lo_reg[0], row_lo_reg[1]), row_lo_reg[2]);
        s2_hi_next      = pix_min(pix_min(row_hi_reg[0], row_hi_reg[1]), row_hi_reg[2]);
        s2_mid_next     = pix_max(pix_min(row_mid_reg[0], row_mid_reg[1]),
                                  pix_min(pix_max(row_mid_reg[0], row_mid_reg[1]),
                                          row_mid_reg[2]));
        s2_replace_next = s1_extreme_reg && (s1_count_reg < cfg.keep_count);
    end

    always_comb
    begin
        if (s2_replace_reg)
        begin
            out_pixel_next = pix_max(pix_min(s2_lo_reg, s2_mid_reg),
                                     pix_min(pix_max(s2_lo_reg, s2_mid_reg), s2_hi_reg));
        end
        else
        begin
            out_pixel_next = s2_center_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= win.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && win.valid)
        begin
            row_lo_reg     <= row_lo_next;
            row_mid_reg    <= row_mid_next;
            row_hi_reg     <= row_hi_next;
            s1_extreme_reg <= s1_extreme_next;
            s1_count_reg   <= s1_count_next;
            s1_center_reg  <= win.center;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_lo_reg      <= s2_lo_next;
            s2_mid_reg     <= s2_mid_next;
            s2_hi_reg      <= s2_hi_next;
            s2_replace_reg <= s2_replace_next;
            s2_center_reg  <= s1_center_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign pix.valid     = s3_valid_reg;
    assign pix.out_pixel = out_pixel_reg;

    `SMPM_ASSERT_NOW(a_extreme_counts_center, s1_valid_reg && s1_extreme_reg,
                     s1_count_reg != '0)
    `SMPM_ASSERT_NEXT(a_stage_advance, s1_valid_reg && s2_ready, s2_valid_reg)
    `SMPM_ASSERT_NEXT(a_center_pass, s2_valid_reg && s3_ready && !s2_replace_reg,
                      out_pixel_reg == $past(s2_center_reg))
    `SMPM_ASSERT_NOW(a_ready_only_when_full, !win.ready,
                     s1_valid_reg && s2_valid_reg && s3_valid_reg && !pix.ready)

endmodule

`default_nettype wire
